[rtl/core/imurot_pkg.sv]
package imurot_pkg;

  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 14;
  localparam int KIND_W    = 3;
  localparam int WRAP_W    = 8;
  localparam int ROW_W     = 3 * COEF_W;
  localparam int N_AXES    = 3;

  // full product, rounded product, row sum (also wide enough for yaw math)
  localparam int PROD_W = DATA_W + COEF_W;
  localparam int RND_W  = PROD_W - COEF_FRAC;
  localparam int SUM_W  = RND_W + 2;

  localparam int TWO_PI_Q   = 411775;
  localparam int FIVE_RAD_Q = 327680;

  localparam logic signed [WRAP_W-1:0] WRAP_MAX = WRAP_W'(127);
  localparam logic signed [WRAP_W-1:0] WRAP_MIN = -WRAP_W'(127);

  localparam logic [KIND_W-1:0] KIND_EULER = KIND_W'(3);

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ROW0 = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_ROW1 = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_ROW2 = REG_IDX_W'(2);

  localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(48'h4000_0000_0000);
  localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(48'h0000_4000_0000);
  localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(48'h0000_0000_4000);

  typedef logic [N_AXES-1:0][ROW_W-1:0] matrix_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } vec_item_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(DATA_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

[rtl/core/imu_frame_rotate_yaw_unwrap.sv]
// Path from the accepting edge to the result on the master side, through
//   the input register, product register, row-sum register and output register.
// Throughput: one request per cycle unless back-pressure fills all four register
//   stages, which hand over independently: a new request enters while one waits.
// Reset (rst_ni, async low): pipeline emptied, yaw history and wrap count
//   cleared, matrix rows load the identity matrix.
module imu_frame_rotate_yaw_unwrap
  import imurot_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config write port
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [ROW_W-1:0]     cfg_data_i,
  // request stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [95:0]          s_axis_tdata_i,   // in_x, in_y, in_z
  input  logic [KIND_W-1:0]    s_axis_tuser_i,   // req_type
  // result stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [103:0]         m_axis_tdata_o,   // out_x, out_y, out_z, wraps_now
  output logic [KIND_W-1:0]    m_axis_tuser_o    // out_kind
);

  // DCM rows, column 0 in the top 16 bits of each row
  logic [ROW_W-1:0] row0_q, row1_q, row2_q;
  matrix_t          matrix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= ROW0_RST;
      row1_q <= ROW1_RST;
      row2_q <= ROW2_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW0: row0_q <= cfg_data_i;
        REG_ROW1: row1_q <= cfg_data_i;
        REG_ROW2: row2_q <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  assign matrix[0] = row0_q;
  assign matrix[1] = row1_q;
  assign matrix[2] = row2_q;

  vec_item_t in_item;
  assign in_item.kind = s_axis_tuser_i;
  assign in_item.x    = s_axis_tdata_i[31:0];
  assign in_item.y    = s_axis_tdata_i[63:32];
  assign in_item.z    = s_axis_tdata_i[95:64];

  // rotation pipeline -> yaw unwrap / output register
  logic      rot_valid, rot_ready;
  vec_item_t rot_item;

  imurot_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .matrix_i    (matrix),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .out_valid_o (rot_valid),
    .out_ready_i (rot_ready),
    .out_item_o  (rot_item)
  );

  vec_item_t                res_item;
  logic signed [WRAP_W-1:0] res_wraps;

  // yaw state lives here; Euler-angle requests update it in arrival order,
  // so every result reports the wrap count as of its own request
  imurot_unwrap u_unwrap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rot_valid),
    .in_ready_o  (rot_ready),
    .in_item_i   (rot_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (res_item),
    .out_wraps_o (res_wraps)
  );

  assign m_axis_tuser_o = res_item.kind;
  assign m_axis_tdata_o = {res_wraps, res_item.z, res_item.y, res_item.x};

  // wrap count saturates at +/-127, never reaches -128
  a_wrap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[103:96] != 8'h80))
    else $error("wrap count out of range");

  // the request side only stalls when every stage is full and the output waits
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("request side stalled without output backpressure");

  // a waiting result holds still until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("waiting result changed before it was taken");

endmodule

[rtl/core/imurot_rotate.sv]
module imurot_rotate
  import imurot_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  matrix_t   matrix_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  vec_item_t in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vec_item_t out_item_o
);

  // stage 1: input register
  logic      v1_q;
  vec_item_t s1_q;
  // stage 2: rounded products
  logic                    v2_q;
  logic [KIND_W-1:0]       kind2_q;
  logic signed [RND_W-1:0] prod_q [N_AXES][N_AXES];
  logic signed [RND_W-1:0] prod_d [N_AXES][N_AXES];
  // stage 3: saturated row sums
  logic      v3_q;
  vec_item_t s3_q;
  vec_item_t s3_d;

  logic rdy1, rdy2, rdy3;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  always_comb begin
    logic signed [DATA_W-1:0] d [N_AXES];
    logic signed [COEF_W-1:0] k;
    logic signed [PROD_W-1:0] p;
    d[0] = s1_q.x;
    d[1] = s1_q.y;
    d[2] = s1_q.z;
    for (int r = 0; r < N_AXES; r++) begin
      for (int c = 0; c < N_AXES; c++) begin
        // column 0 in the top bits of the row
        k = matrix_i[r][ROW_W-1-COEF_W*c -: COEF_W];
        p = PROD_W'(d[c]) * PROD_W'(k) + PROD_W'(1 <<< (COEF_FRAC - 1));
        prod_d[r][c] = p[PROD_W-1:COEF_FRAC];
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc [N_AXES];
    for (int r = 0; r < N_AXES; r++) begin
      acc[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
    end
    s3_d.kind = kind2_q;
    s3_d.x    = sat_data(acc[0]);
    s3_d.y    = sat_data(acc[1]);
    s3_d.z    = sat_data(acc[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) s1_q <= in_item_i;
    if (rdy2 && v1_q) begin
      kind2_q <= s1_q.kind;
      prod_q  <= prod_d;
    end
    if (rdy3 && v2_q) s3_q <= s3_d;
  end

  assign out_valid_o = v3_q;
  assign out_item_o  = s3_q;

endmodule

[rtl/core/imurot_unwrap.sv]
module imurot_unwrap
  import imurot_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  vec_item_t                in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output vec_item_t                out_item_o,
  output logic signed [WRAP_W-1:0] out_wraps_o
);

  logic signed [DATA_W-1:0] prev_yaw_q, prev_yaw_d;
  logic signed [WRAP_W-1:0] wrap_q, wrap_d;
  logic                     ov_q;
  vec_item_t                res_q, res_d;
  logic signed [WRAP_W-1:0] wraps_out_q;
  logic                     take;

  assign in_ready_o = !ov_q || out_ready_i;
  assign take       = in_ready_o && in_valid_i;

  always_comb begin
    logic signed [SUM_W-1:0] yaw;
    logic signed [SUM_W-1:0] diff;
    yaw  = SUM_W'(in_item_i.z) + SUM_W'(wrap_q) * SUM_W'(TWO_PI_Q);
    diff = yaw - SUM_W'(prev_yaw_q);
    wrap_d = wrap_q;
    if (diff > SUM_W'(FIVE_RAD_Q) || diff < -SUM_W'(FIVE_RAD_Q)) begin
      if (diff > 0) begin
        if (wrap_q > WRAP_MIN) wrap_d = wrap_q - WRAP_W'(1);
        yaw = yaw - SUM_W'(TWO_PI_Q);
      end else begin
        if (wrap_q < WRAP_MAX) wrap_d = wrap_q + WRAP_W'(1);
        yaw = yaw + SUM_W'(TWO_PI_Q);
      end
    end
    prev_yaw_d = sat_data(yaw);
    res_d = in_item_i;
    if (in_item_i.kind == KIND_EULER) res_d.z = prev_yaw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q       <= 1'b0;
      prev_yaw_q <= '0;
      wrap_q     <= '0;
    end else begin
      if (in_ready_o) ov_q <= in_valid_i;
      if (take && in_item_i.kind == KIND_EULER) begin
        prev_yaw_q <= prev_yaw_d;
        wrap_q     <= wrap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q       <= res_d;
      wraps_out_q <= (in_item_i.kind == KIND_EULER) ? wrap_d : wrap_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = res_q;
  assign out_wraps_o = wraps_out_q;

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import imurot_pkg::*;

  // Vector kinds as carried in tuser (upper three codes are reserved).
  typedef enum logic [KIND_W-1:0] {
    K_MAG   = 3'd0,
    K_GYRO  = 3'd1,
    K_ACCEL = 3'd2,
    K_EULER = 3'd3,
    K_RATES = 3'd4,
    K_RSV5  = 3'd5,
    K_RSV6  = 3'd6,
    K_RSV7  = 3'd7
  } vec_kind_e;

  // Index 3 is decoded by nothing; writes there must leave the matrix alone.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(3);

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam longint                   RND_HALF = longint'(1) << (COEF_FRAC - 1);

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int N_PHASES     = 8;
  localparam int RAND_PER_PH  = 180;
  localparam int HOLD_AT      = 400;   // accepted requests before the long stall
  localparam int HOLD_CYCLES  = 64;
  localparam int DRAIN_CYCLES = 8;     // margin beyond the pipeline latency

  // One body-frame result, fields as on the master side.
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [WRAP_W-1:0] wraps;
  } body_vec_t;

  // Directed stimulus row: either a register write or a request, optionally
  // with a hand-computed result instead of the predicted one.
  typedef struct {
    bit                       is_cfg;
    logic [REG_IDX_W-1:0]     idx;
    logic [ROW_W-1:0]         val;
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    bit                       typed;
    body_vec_t                want;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_idx = '0;
  logic [ROW_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic [95:0]          s_tdata = '0;
  logic [KIND_W-1:0]    s_tuser = '0;
  logic                 m_tready = 1'b0;
  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [103:0]         m_axis_tdata_o;
  logic [KIND_W-1:0]    m_axis_tuser_o;

  // Predictor state: a private copy of the matrix and of the yaw tracker.
  logic [ROW_W-1:0]         mat_rows [N_AXES];
  logic signed [DATA_W-1:0] yaw_hist;
  logic signed [WRAP_W-1:0] wrap_cnt;

  body_vec_t body_frame_q [$];   // expected results, oldest first
  dir_row_t  dir_tab [$];

  int  n_fail     = 0;
  int  n_accepted = 0;
  int  n_cycles   = 0;
  bit  quiet      = 1'b0;        // no idling on either side
  bit  held_off   = 1'b0;

  always #5 clk_i = ~clk_i;

  imu_frame_rotate_yaw_unwrap DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),          // in_x, in_y, in_z
    .s_axis_tuser_i  (s_tuser),          // req_type
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // out_x, out_y, out_z, wraps_now
    .m_axis_tuser_o  (m_axis_tuser_o)    // out_kind
  );

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic logic signed [DATA_W-1:0] clamp_q16(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return DATA_W'(v);
  endfunction

  // One matrix row times the input vector. Each product is rounded half up
  // to Q16.16 on its own; only the sum of the three is saturated.
  function automatic logic signed [DATA_W-1:0] dot_row(
      input logic [ROW_W-1:0] row, input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b, input logic signed [DATA_W-1:0] c);
    logic signed [DATA_W-1:0] d [N_AXES];
    logic signed [COEF_W-1:0] k;
    longint acc;
    d[0] = a;
    d[1] = b;
    d[2] = c;
    acc = 0;
    for (int i = 0; i < N_AXES; i++) begin
      // column 0 sits in the top bits of the row
      k = $signed(row[ROW_W-1-COEF_W*i -: COEF_W]);
      acc += (longint'(d[i]) * longint'(k) + RND_HALF) >>> COEF_FRAC;
    end
    return clamp_q16(acc);
  endfunction

  // Rotates one request and, for Euler angles, runs the yaw unwrap against
  // the tracker state, which it updates.
  function automatic body_vec_t predict_body_vec(
      input logic [KIND_W-1:0] kind, input logic signed [DATA_W-1:0] x,
      input logic signed [DATA_W-1:0] y, input logic signed [DATA_W-1:0] z);
    body_vec_t r;
    longint yaw;
    longint diff;
    r.kind = kind;
    r.x = dot_row(mat_rows[0], x, y, z);
    r.y = dot_row(mat_rows[1], x, y, z);
    r.z = dot_row(mat_rows[2], x, y, z);
    if (kind == KIND_EULER) begin
      yaw  = longint'(r.z) + longint'(wrap_cnt) * TWO_PI_Q;
      diff = yaw - longint'(yaw_hist);
      if (diff > FIVE_RAD_Q || diff < -FIVE_RAD_Q) begin
        // count holds at its limit, but the 2*pi correction still applies
        if (diff > 0) begin
          if (wrap_cnt > WRAP_MIN) wrap_cnt--;
          yaw -= TWO_PI_Q;
        end else begin
          if (wrap_cnt < WRAP_MAX) wrap_cnt++;
          yaw += TWO_PI_Q;
        end
      end
      yaw_hist = clamp_q16(yaw);
      r.z = yaw_hist;
    end
    r.wraps = wrap_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic dir_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                       input logic [ROW_W-1:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic dir_row_t vec_row(input logic [KIND_W-1:0] kind,
      input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
      input logic signed [DATA_W-1:0] z);
    dir_row_t r;
    r = '{default: '0};
    r.kind = kind;
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  function automatic dir_row_t chk_row(input logic [KIND_W-1:0] kind,
      input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
      input logic signed [DATA_W-1:0] z, input logic signed [DATA_W-1:0] ex,
      input logic signed [DATA_W-1:0] ey, input logic signed [DATA_W-1:0] ez,
      input logic signed [WRAP_W-1:0] ew);
    dir_row_t r;
    r = vec_row(kind, x, y, z);
    r.typed = 1'b1;
    r.want = '{kind: kind, x: ex, y: ey, z: ez, wraps: ew};
    return r;
  endfunction

  // Mix of corner values, small angles (so Euler steps land near the 5 rad
  // threshold) and full-range noise.
  function automatic logic signed [DATA_W-1:0] pick_q16();
    case ($urandom_range(0, 15))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return -1;
      4:       return 1;
      5, 6, 7, 8:
        return DATA_W'(longint'($urandom_range(0, 16 * 65536)) - 8 * 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef(input bit corners_only);
    if (corners_only) return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    case ($urandom_range(0, 7))
      0:       return 16'h4000;   // +1.0
      1:       return 16'hC000;   // -1.0
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      4:       return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    int r;
    r = $urandom_range(0, 15);
    if (r < 5) return K_EULER;
    if (r < 14) return KIND_W'($urandom_range(K_MAG, K_RATES));
    return KIND_W'($urandom_range(K_RSV5, K_RSV7));
  endfunction

  // Hold a request on the slave side until taken; predict at the accepting
  // edge so the tracker sees requests in order. Leaves tvalid high: the
  // caller either offers the next request or drops it.
  task automatic offer_vec(input logic [KIND_W-1:0] kind,
      input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
      input logic signed [DATA_W-1:0] z, input bit typed, input body_vec_t want);
    body_vec_t pred;
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_body_vec(kind, x, y, z);
    body_frame_q.push_back(typed ? want : pred);
    n_accepted++;
    @(negedge clk_i);
  endtask

  task automatic offer_rand(input logic [KIND_W-1:0] kind,
      input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
      input logic signed [DATA_W-1:0] z);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    offer_vec(kind, x, y, z, 1'b0, '0);
  endtask

  // Register writes only with the pipeline empty. Every request yields a
  // result, so an empty queue means nothing is still in flight.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                           input logic [ROW_W-1:0] val);
    s_tvalid <= 1'b0;
    while (body_frame_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_ROW0: mat_rows[0] = val;
      REG_ROW1: mat_rows[1] = val;
      REG_ROW2: mat_rows[2] = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------
  // Identity matrix out of reset. Yaw tracker walk-through (rad):
  //   +1 -> -3 (4 rad step, no wrap) -> +3 (6 rad step: wrap count -1,
  //   yaw 3-2pi) -> same again (no step) -> -3 (drops 6 rad: count back
  //   to 0) -> +2 (exactly 5 rad, no wrap) -> one LSB past 5 rad (wraps).
  initial begin
    dir_tab.push_back(chk_row(K_MAG, Q_ONE, 2 * Q_ONE, 3 * Q_ONE,
                              Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 0));
    dir_tab.push_back(chk_row(K_GYRO, Q_MAX, Q_MIN, 0, Q_MAX, Q_MIN, 0, 0));
    dir_tab.push_back(chk_row(K_ACCEL, -1, 1, -1, -1, 1, -1, 0));
    dir_tab.push_back(chk_row(K_RATES, 0, 0, Q_MAX, 0, 0, Q_MAX, 0));
    dir_tab.push_back(chk_row(K_EULER, 0, 0, 65536, 0, 0, 65536, 0));
    dir_tab.push_back(chk_row(K_EULER, 0, 0, -196608, 0, 0, -196608, 0));
    dir_tab.push_back(chk_row(K_EULER, 0, 0, 196608, 0, 0, -215167, -1));
    dir_tab.push_back(chk_row(K_EULER, 0, 0, 196608, 0, 0, -215167, -1));
    dir_tab.push_back(chk_row(K_EULER, 0, 0, -196608, 0, 0, -196608, 0));
    // reserved kind: plain rotation, tracker untouched
    dir_tab.push_back(chk_row(K_RSV5, 1, 2, 3, 1, 2, 3, 0));
    dir_tab.push_back(chk_row(K_EULER, 0, 0, 131072, 0, 0, 131072, 0));
    dir_tab.push_back(chk_row(K_EULER, 0, 0, 458753, 0, 0, 46978, -1));
    dir_tab.push_back(vec_row(K_RSV6, 32'sh1234_5678, -32'sd77, 32'sh0ABC_DEF0));
    dir_tab.push_back(vec_row(K_RSV7, -32'sd5, Q_MAX, Q_MIN));
    dir_tab.push_back(vec_row(K_EULER, Q_MAX, Q_MIN, Q_MAX));
    // extreme coefficients: sums overflow and saturate
    dir_tab.push_back(cfg_row(REG_ROW0, 48'h8000_8000_8000));
    dir_tab.push_back(cfg_row(REG_ROW1, 48'h7FFF_7FFF_7FFF));
    dir_tab.push_back(cfg_row(REG_ROW2, 48'h7FFF_8000_0001));
    dir_tab.push_back(vec_row(K_MAG, Q_MAX, Q_MAX, Q_MAX));
    dir_tab.push_back(vec_row(K_GYRO, Q_MIN, Q_MIN, Q_MIN));
    dir_tab.push_back(vec_row(K_EULER, Q_MIN, Q_MAX, Q_MIN));
    dir_tab.push_back(vec_row(K_ACCEL, -1, -1, -1));
    dir_tab.push_back(vec_row(K_RATES, 1, 1, 1));
    // write to the undecoded index must not land anywhere
    dir_tab.push_back(cfg_row(REG_SPARE, '1));
    dir_tab.push_back(vec_row(K_MAG, Q_ONE, Q_ONE, Q_ONE));
    dir_tab.push_back(cfg_row(REG_ROW0, ROW0_RST));
    dir_tab.push_back(cfg_row(REG_ROW1, ROW1_RST));
    dir_tab.push_back(cfg_row(REG_ROW2, ROW2_RST));
    dir_tab.push_back(vec_row(K_MAG, Q_ONE, 2, 3));
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [ROW_W-1:0]         rows [N_AXES];
    logic signed [DATA_W-1:0] rz;
    longint                   margin;
    int                       mode;
    int                       n_chase;
    bit                       chase_up;

    mat_rows[0] = ROW0_RST;
    mat_rows[1] = ROW1_RST;
    mat_rows[2] = ROW2_RST;
    yaw_hist    = '0;
    wrap_cnt    = '0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        offer_vec(dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
                  dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random phases, each with its own matrix. Identity phases first chase
    // the wrap count into its limit: each Euler request lands just past
    // 5 rad from the tracked yaw, so every one of them wraps.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      mode = ph % 4;
      for (int r = 0; r < N_AXES; r++) begin
        case (mode)
          0:       rows[r] = (r == 0) ? ROW0_RST : (r == 1) ? ROW1_RST : ROW2_RST;
          2:       rows[r] = (ph < 4) ? '0 : '1;
          default: rows[r] = {pick_coef(mode == 1), pick_coef(mode == 1),
                              pick_coef(mode == 1)};
        endcase
      end
      if (mode == 3) write_reg(REG_SPARE, ROW_W'({$urandom, $urandom}));
      write_reg(REG_ROW0, rows[0]);
      write_reg(REG_ROW1, rows[1]);
      write_reg(REG_ROW2, rows[2]);

      quiet = (ph == N_PHASES - 1);

      n_chase  = (ph == 0) ? 160 : (ph == 4) ? 280 : 0;
      chase_up = (ph == 0);
      for (int i = 0; i < n_chase; i++) begin
        margin = longint'(FIVE_RAD_Q) + longint'($urandom_range(1, 65536));
        rz = clamp_q16(longint'(yaw_hist) - longint'(wrap_cnt) * TWO_PI_Q +
                       (chase_up ? -margin : margin));
        offer_rand(K_EULER, $urandom, $urandom, rz);
      end

      for (int i = 0; i < RAND_PER_PH; i++) begin
        offer_rand(pick_kind(), pick_q16(), pick_q16(), pick_q16());
      end
    end

    s_tvalid <= 1'b0;
    while (body_frame_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Result side: random stalls, one long hold-off so the pipeline backs up
  // into the request side, none in the last phase.
  // ---------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held_off && n_accepted >= HOLD_AT) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input longint want,
                             input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    body_vec_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (body_frame_q.size() == 0) begin
        $error("result with no request outstanding: tuser %0d tdata %h",
               m_axis_tuser_o, m_axis_tdata_o);
        n_fail++;
      end else begin
        want = body_frame_q.pop_front();
        check_field("out_kind", want.kind, m_axis_tuser_o);
        check_field("out_x", want.x, $signed(m_axis_tdata_o[31:0]));
        check_field("out_y", want.y, $signed(m_axis_tdata_o[63:32]));
        check_field("out_z", want.z, $signed(m_axis_tdata_o[95:64]));
        check_field("wraps_now", want.wraps, $signed(m_axis_tdata_o[103:96]));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

[sim.f]
rtl/core/imurot_pkg.sv
rtl/core/imurot_rotate.sv
rtl/core/imurot_unwrap.sv
rtl/core/imu_frame_rotate_yaw_unwrap.sv
tb/tb.sv
